/* rtl/core/trapezoid_integrator_spike_merger_macros.svh */
// assertion macros for the trapezoid integrator spike merger
`ifndef TRAPEZOID_INTEGRATOR_SPIKE_MERGER_MACROS_SVH
`define TRAPEZOID_INTEGRATOR_SPIKE_MERGER_MACROS_SVH

// same-cycle implication, disabled in reset
`define TISM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tism check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define TISM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tism check failed: next-cycle implication");

`endif

/* rtl/core/tism_pkg.sv */
// types and constants of the trapezoid integrator spike merger
package tism_pkg;

  typedef struct packed {
    logic [23:0]        diameter;
    logic signed [31:0] cumulative;
    logic signed [31:0] derivative;
    logic               interval_start;
    logic               cap_enable;
    logic [30:0]        cap;
    logic               new_series;
  } sample_t;

  typedef struct packed {
    logic               pair_valid;
    logic signed [39:0] integral;
    logic [30:0]        gap_taken;
    logic [38:0]        singular_weight;
    logic [1:0]         spike_action;
    logic [10:0]        spike_count;
    logic [23:0]        spike_diameter;
    logic [38:0]        spike_weight;
    logic [23:0]        spike_bracket;
  } result_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_MUL_TRAP = 8'b0000_0010,
    ST_GAP      = 8'b0000_0100,
    ST_MUL_A    = 8'b0000_1000,
    ST_MUL_B    = 8'b0001_0000,
    ST_SUM      = 8'b0010_0000,
    ST_DIV      = 8'b0100_0000,
    ST_OUT      = 8'b1000_0000
  } state_t;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_OPEN  = 2'd1;
  localparam logic [1:0] ACT_MERGE = 2'd2;

  localparam logic [30:0] FLOOR_RESET = 31'd10737;
  localparam int unsigned DIV_STEPS   = 24;

  localparam logic signed [41:0] INT40_MAX = 42'sh00_7FFF_FFFF_FF;
  localparam logic signed [41:0] INT40_MIN = -42'sh00_8000_0000_00;
  localparam logic signed [41:0] GAP_MAX   = 42'sh0_7FFF_FFFF;
  localparam logic [38:0]        W39_MAX   = 39'h7F_FFFF_FFFF;
  localparam logic [23:0]        W24_MAX   = 24'hFF_FFFF;

endpackage

/* rtl/core/trapezoid_integrator_spike_merger.sv */
// trapezoid integrator with spike detection and merging, top level
// sequence: a sample with no pair goes from idle straight to the output state, a pair
//   first passes the trapezoid multiply and gap states, a merged pair then also multiply A,
//   multiply B, sum, 24 divider steps and a merge commit; the next sample is taken the cycle
//   after the result is loaded, a stalled result holds the sequencer in its output state
// reset (rst, synchronous): clears integral, weights, spike state, floor to 10737
`include "trapezoid_integrator_spike_merger_macros.svh"

module trapezoid_integrator_spike_merger #(
  parameter int unsigned MAX_SPIKES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  tism_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output tism_pkg::result_t result,
  input  logic              cfg_write,
  input  logic [30:0]       cfg_data
);
  import tism_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_SPIKES + 1);
  localparam int unsigned DIV_W = $clog2(DIV_STEPS);

  // sequencer and configuration
  state_t state;
  logic [30:0] spike_floor;

  // captured sample and pair decision
  sample_t cur;
  logic    pair;

  // state carried between samples
  logic [23:0]        prev_diameter;
  logic signed [31:0] prev_cumulative;
  logic signed [31:0] prev_derivative;
  logic               have_prev;
  logic signed [39:0] running_integral;
  logic [38:0]        running_singular;
  logic [CNT_W-1:0]   count_of_spikes;
  logic [23:0]        last_spike_diameter;
  logic [38:0]        last_spike_weight;
  logic [23:0]        last_spike_bracket;
  logic               last_end_valid;
  logic [23:0]        last_end;

  // per-pair working registers
  logic [30:0] gap_taken;
  logic [1:0]  spike_action;
  logic [23:0] mid_reg;
  logic [39:0] total_reg;
  logic [24:0] nb_reg;
  logic        merged_flag;

  // shared multiplier and divider datapath
  logic signed [40:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [65:0] prod;
  logic [63:0]        num_part;
  logic [39:0]        rem;
  logic [23:0]        dvd_lo;
  logic [DIV_W-1:0]   div_cnt;

  // pair arithmetic, valid while cur and prev are stable
  logic signed [24:0] delta;
  logic signed [32:0] dsum;
  logic signed [40:0] trap;
  logic signed [32:0] dc;
  logic signed [41:0] gap_raw;
  logic signed [41:0] gap_capped;
  logic signed [41:0] gap_c;
  logic signed [41:0] isum;
  logic signed [39:0] isum_sat;
  logic               spike;
  logic [30:0]        w;
  logic [24:0]        dsum_mid;
  logic [23:0]        mid;
  logic [23:0]        br;
  logic [24:0]        nb;
  logic signed [24:0] spread;
  logic signed [29:0] lim;
  logic               merge;
  logic [39:0]        total;
  logic [39:0]        singular_sum;
  logic [63:0]        num_full;
  logic [40:0]        trial;
  logic               trial_ge;
  logic [CNT_W+10:0]  count_ext;
  logic               sample_take;
  logic               result_take;
  logic               result_load;

  assign sample_stall = (state != ST_IDLE);
  assign sample_take  = sample_valid && !sample_stall;
  assign result_take  = result_valid && !result_stall;
  // output register free or emptied this cycle, and no merge commit pending
  assign result_load  = (state == ST_OUT) && (spike_action != ACT_MERGE)
                     && (!result_valid || !result_stall);

  always_comb begin
    delta = $signed({1'b0, cur.diameter}) - $signed({1'b0, prev_diameter});
    dsum  = $signed({prev_derivative[31], prev_derivative})
          + $signed({cur.derivative[31], cur.derivative});

    // floor of product / 2^17; the product fits in 58 bits
    trap = $signed(prod[57:17]);

    dc = $signed({prev_cumulative[31], prev_cumulative})
       - $signed({cur.cumulative[31], cur.cumulative});
    gap_raw = $signed({{9{dc[32]}}, dc}) - $signed({trap[40], trap});

    gap_capped = gap_raw;
    if (cur.cap_enable && (gap_raw > $signed({11'b0, cur.cap}))) begin
      gap_capped = $signed({11'b0, cur.cap});
    end
    gap_c = (gap_capped > GAP_MAX) ? GAP_MAX : gap_capped;
    spike = gap_c > $signed({11'b0, spike_floor});
    w     = gap_c[30:0];

    isum = $signed({{2{running_integral[39]}}, running_integral})
         + $signed({trap[40], trap});
    if (isum > INT40_MAX) begin
      isum_sat = INT40_MAX[39:0];
    end else if (isum < INT40_MIN) begin
      isum_sat = INT40_MIN[39:0];
    end else begin
      isum_sat = isum[39:0];
    end

    dsum_mid = {1'b0, prev_diameter} + {1'b0, cur.diameter};
    mid      = dsum_mid[24:1];
    // falling diameter gives an empty bracket
    br       = (delta > 25'sd0) ? delta[23:0] : 24'd0;
    nb       = {1'b0, br} + {1'b0, last_spike_bracket};
    spread   = $signed({1'b0, mid}) - $signed({1'b0, last_spike_diameter});
    lim      = $signed({1'b0, nb, 4'b0});
    // merge when touching the last spike's end or within sixteen brackets
    merge    = (count_of_spikes != '0)
            && ((last_end_valid && (last_end == prev_diameter))
                || ($signed({{5{spread[24]}}, spread}) < lim));
    total    = {1'b0, last_spike_weight} + {9'b0, w};

    singular_sum = {1'b0, running_singular} + {9'b0, w};

    // shared multiplier operand select
    case (state)
      ST_MUL_TRAP: begin
        mul_a = $signed({{8{dsum[32]}}, dsum});
        mul_b = delta;
      end
      ST_MUL_A: begin
        mul_a = $signed({2'b0, last_spike_weight});
        mul_b = $signed({1'b0, last_spike_diameter});
      end
      ST_MUL_B: begin
        mul_a = $signed({10'b0, gap_taken});
        mul_b = $signed({1'b0, mid_reg});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    // rounded numerator: sum of products plus half the total weight
    num_full = num_part + prod[63:0] + {25'b0, total_reg[39:1]};

    // restoring divider step
    trial    = {rem, dvd_lo[23]};
    trial_ge = trial >= {1'b0, total_reg};

    count_ext = (CNT_W + 11)'(count_of_spikes);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      spike_floor         <= FLOOR_RESET;
      result_valid        <= 1'b0;
      prev_diameter       <= '0;
      prev_cumulative     <= '0;
      prev_derivative     <= '0;
      have_prev           <= 1'b0;
      running_integral    <= '0;
      running_singular    <= '0;
      count_of_spikes     <= '0;
      last_spike_diameter <= '0;
      last_spike_weight   <= '0;
      last_spike_bracket  <= '0;
      last_end_valid      <= 1'b0;
      last_end            <= '0;
      div_cnt             <= '0;
    end else begin
      if (cfg_write) begin
        spike_floor <= cfg_data;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_take) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (sample_take) begin
            cur          <= sample;
            pair         <= have_prev && !sample.interval_start && !sample.new_series;
            gap_taken    <= '0;
            spike_action <= ACT_NONE;
            if (sample.new_series) begin
              running_integral    <= '0;
              running_singular    <= '0;
              count_of_spikes     <= '0;
              last_spike_diameter <= '0;
              last_spike_weight   <= '0;
              last_spike_bracket  <= '0;
              last_end_valid      <= 1'b0;
              last_end            <= '0;
            end
            if (have_prev && !sample.interval_start && !sample.new_series) begin
              state <= ST_MUL_TRAP;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_MUL_TRAP: begin
          prod  <= mul_a * mul_b;
          state <= ST_GAP;
        end
        ST_GAP: begin
          running_integral <= isum_sat;
          state            <= ST_OUT;
          if (spike) begin
            gap_taken        <= w;
            mid_reg          <= mid;
            total_reg        <= total;
            nb_reg           <= nb;
            last_end         <= cur.diameter;
            last_end_valid   <= 1'b1;
            running_singular <= (singular_sum > {1'b0, W39_MAX}) ? W39_MAX
                                                                 : singular_sum[38:0];
            if (merge) begin
              spike_action <= ACT_MERGE;
              state        <= ST_MUL_A;
            end else begin
              spike_action        <= ACT_OPEN;
              last_spike_diameter <= mid;
              last_spike_weight   <= {8'b0, w};
              last_spike_bracket  <= br;
              if (count_of_spikes < CNT_W'(MAX_SPIKES)) begin
                count_of_spikes <= count_of_spikes + 1'b1;
              end
            end
          end
        end
        ST_MUL_A: begin
          prod  <= mul_a * mul_b;
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          num_part <= prod[63:0];
          prod     <= mul_a * mul_b;
          state    <= ST_SUM;
        end
        ST_SUM: begin
          // quotient stays below 2^24, so the top part is already below the total
          rem     <= num_full[63:24];
          dvd_lo  <= num_full[23:0];
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem    <= trial_ge ? 40'(trial - {1'b0, total_reg}) : trial[39:0];
          dvd_lo <= {dvd_lo[22:0], trial_ge};
          if (div_cnt == DIV_W'(DIV_STEPS - 1)) begin
            state <= ST_OUT;
          end else begin
            div_cnt <= div_cnt + 1'b1;
          end
        end
        ST_OUT: begin
          if (spike_action == ACT_MERGE) begin
            last_spike_diameter <= dvd_lo;
            last_spike_weight   <= (total_reg > {1'b0, W39_MAX}) ? W39_MAX
                                                                 : total_reg[38:0];
            last_spike_bracket  <= nb_reg[24] ? W24_MAX : nb_reg[23:0];
            spike_action        <= ACT_NONE;
          end else if (result_load) begin
            result.pair_valid      <= pair;
            result.integral        <= running_integral;
            result.gap_taken       <= gap_taken;
            result.singular_weight <= running_singular;
            result.spike_action    <= merged_flag ? ACT_MERGE : spike_action;
            result.spike_count     <= count_ext[10:0];
            result.spike_diameter  <= last_spike_diameter;
            result.spike_weight    <= last_spike_weight;
            result.spike_bracket   <= last_spike_bracket;
            prev_diameter          <= cur.diameter;
            prev_cumulative        <= cur.cumulative;
            prev_derivative        <= cur.derivative;
            have_prev              <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a merge commit leaves the action as none, so the word after it reports merge
  always_ff @(posedge clk) begin
    if (rst) begin
      merged_flag <= 1'b0;
    end else if (state == ST_GAP) begin
      merged_flag <= spike && merge;
    end else if (state == ST_IDLE) begin
      merged_flag <= 1'b0;
    end
  end

  `TISM_ASSERT_NOW(a_div_bound, state == ST_DIV, div_cnt < DIV_W'(DIV_STEPS))
  `TISM_ASSERT_NOW(a_count_limit, 1'b1, count_of_spikes <= CNT_W'(MAX_SPIKES))
  `TISM_ASSERT_NOW(a_end_has_spike, last_end_valid, count_of_spikes != '0)
  `TISM_ASSERT_NEXT(a_singular_grows, !(sample_take && sample.new_series),
                    running_singular >= $past(running_singular))

endmodule
